// ===== hdl/lqta_pkg.sv =====
// Shared types, widths and constants of the link quality telemetry aggregator.
package lqta_pkg;

	localparam int DEF_PEER_SLOTS = 8;

	localparam int QUAL_W = 15;
	localparam int PEER_W = 32;
	localparam int RTT_W  = 24;
	localparam int BW_W   = 32;
	localparam int HYST_W = 16;
	localparam int LQ_W   = 7;
	localparam int LAST_Q_W = 8;

	localparam logic [QUAL_W-1:0]   FULL_SCALE  = 15'd25600;
	localparam logic [HYST_W-1:0]   HYST_RESET  = 16'd15;
	localparam logic [LAST_Q_W-1:0] LAST_Q_INIT = 8'hFF;
	localparam logic [RTT_W-1:0]    LAST_R_INIT = 24'hFFFFFF;

	localparam logic [1:0] OP_STATS  = 2'd0;
	localparam logic [1:0] OP_FLOW   = 2'd1;
	localparam logic [1:0] OP_ATTACH = 2'd2;
	localparam logic [1:0] OP_DETACH = 2'd3;

	typedef struct packed {
		logic [1:0]        op;
		logic [PEER_W-1:0] peer_id;
		logic [QUAL_W-1:0] quality;
		logic [RTT_W-1:0]  rtt_ms;
		logic [BW_W-1:0]   bandwidth;
	} item_t;

	typedef struct packed {
		logic [LQ_W-1:0]  quality_pct;
		logic [RTT_W-1:0] worst_rtt_ms;
	} result_t;

	typedef struct packed {
		logic [PEER_W-1:0] peer;
		logic [QUAL_W-1:0] quality;
		logic [RTT_W-1:0]  rtt;
		logic [BW_W-1:0]   bandwidth;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/lqta_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module lqta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/link_quality_telemetry_aggregator_unit.sv =====
// Top level of the link quality telemetry aggregator: peer table, averaging and report filter.
//
//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+---------------------------------------
//  item     | in        | start high, busy low       | op, peer_id, quality, rtt_ms, bandwidth
//  result   | out       | result_valid, one cycle    | quality_pct, worst_rtt_ms
//  cfg      | in        | cfg_valid and cfg_ready    | rtt_hysteresis (16 bit)
//
// Attach and detach words finish in the accepting cycle; busy stays low.
// A stats word holds busy through the id search sweep, write, sum sweep, multiply, compare,
// 7-step divide and emit; the divide is skipped if the cap decides.
// A flow word skips search and write; a dropped stats word frees the block after the search.
// Reset clears the valid bits, input-leg quality and report history; the RAM needs no clearing.
// A report shows for one cycle right after busy falls; the receiver cannot stall.
module link_quality_telemetry_aggregator_unit
	import lqta_pkg::*;
#(
	parameter int PEER_SLOTS = DEF_PEER_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  item_t             item,
	output logic              result_valid,
	output result_t           result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [HYST_W-1:0] cfg_data
);

	localparam int IDX_W  = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
	localparam int CNT_W  = $clog2(PEER_SLOTS + 1);
	localparam int QS_W   = QUAL_W + CNT_W;
	localparam int BS_W   = BW_W + CNT_W;
	localparam int PROD_W = QUAL_W + BW_W;
	localparam int NUM_W  = PROD_W + CNT_W;
	localparam int DEN_W  = BS_W;
	localparam int REM_W  = NUM_W + 1;

	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(PEER_SLOTS);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SEARCH = 4'd1;
	localparam logic [3:0] ST_WRITE  = 4'd2;
	localparam logic [3:0] ST_SUM    = 4'd3;
	localparam logic [3:0] ST_MULT   = 4'd4;
	localparam logic [3:0] ST_CMP    = 4'd5;
	localparam logic [3:0] ST_DIV    = 4'd6;
	localparam logic [3:0] ST_EMIT   = 4'd7;

	logic [3:0] st_q;

	// architectural state
	logic [PEER_SLOTS-1:0] valid_q;
	logic [QUAL_W-1:0]     leg_q;
	logic                  attached_q;
	logic [LAST_Q_W-1:0]   last_q_q;
	logic [RTT_W-1:0]      last_rtt_q;
	logic [HYST_W-1:0]     hyst_q;

	// held input word
	item_t item_q;

	// sweep control
	logic [CNT_W-1:0] cnt_q;
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             v_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [QUAL_W-1:0] q_s2;
	logic [BW_W-1:0]   bw_s2;
	logic [RTT_W-1:0]  rtt_s2;

	// search results
	logic             found_q;
	logic             free_found_q;
	logic [IDX_W-1:0] match_q;
	logic [IDX_W-1:0] free_q;

	// sums
	logic [CNT_W-1:0] n_q;
	logic [NUM_W-1:0] wsum_q;
	logic [QS_W-1:0]  qsum_q;
	logic [BS_W-1:0]  bwsum_q;
	logic [RTT_W-1:0] worst_q;

	// divide
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] capden_q;
	logic [REM_W-1:0] rem_q;
	logic [2:0]       k_q;
	logic [LQ_W-1:0]  lq_q;

	// RAM ports
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	entry_t           ram_rdata;
	logic [ENTRY_W-1:0] ram_rbits;

	logic sweeping;
	logic issue;
	logic [NUM_W-1:0] num_sel;
	logic [DEN_W-1:0] den_sel;
	logic [REM_W-1:0] trial;
	logic [RTT_W-1:0] rtt_diff;
	logic             report;

	assign busy      = (st_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign sweeping = (st_q == ST_SEARCH) || (st_q == ST_SUM);
	assign issue    = sweeping && (cnt_q < SLOTS_C);

	assign ram_we    = (st_q == ST_WRITE);
	assign ram_waddr = found_q ? match_q : free_q;
	assign ram_wdata = '{peer: item_q.peer_id, quality: item_q.quality,
	                     rtt: item_q.rtt_ms, bandwidth: item_q.bandwidth};
	assign ram_rdata = entry_t'(ram_rbits);

	lqta_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(PEER_SLOTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ENTRY_W'(ram_wdata)),
		.raddr(cnt_q[IDX_W-1:0]),
		.rdata(ram_rbits)
	);

	// pick the mean: no peers -> full scale, zero bandwidth -> plain mean, else weighted
	always_comb begin
		if (n_q == '0) begin
			num_sel = NUM_W'(FULL_SCALE);
			den_sel = DEN_W'(1);
		end else if (bwsum_q == '0) begin
			num_sel = NUM_W'(qsum_q);
			den_sel = DEN_W'(n_q);
		end else begin
			num_sel = wsum_q;
			den_sel = bwsum_q;
		end
	end

	assign trial    = REM_W'(den_q) << (5'd8 + {2'b0, k_q});
	assign rtt_diff = (worst_q > last_rtt_q) ? worst_q - last_rtt_q : last_rtt_q - worst_q;
	assign report   = attached_q &&
	                  ((LAST_Q_W'(lq_q) != last_q_q) || (rtt_diff > RTT_W'(hyst_q)));

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyst_q <= HYST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			hyst_q <= cfg_data;
		end
	end

	// sweep pipeline: address, then data, then product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= (st_q == ST_SUM) && v_s1 && valid_q[idx_s1];
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= cnt_q[IDX_W-1:0];
		prod_s2 <= PROD_W'(ram_rdata.quality) * PROD_W'(ram_rdata.bandwidth);
		q_s2    <= ram_rdata.quality;
		bw_s2   <= ram_rdata.bandwidth;
		rtt_s2  <= ram_rdata.rtt;
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			valid_q      <= '0;
			leg_q        <= FULL_SCALE;
			attached_q   <= 1'b0;
			last_q_q     <= LAST_Q_INIT;
			last_rtt_q   <= LAST_R_INIT;
			cnt_q        <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			// show the report for exactly the cycle after emit
			result_valid <= (st_q == ST_EMIT) && report;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			unique case (st_q)
				ST_IDLE: begin
					cnt_q        <= '0;
					found_q      <= 1'b0;
					free_found_q <= 1'b0;
					if (start) begin
						unique case (item.op)
							OP_STATS:  st_q <= ST_SEARCH;
							OP_FLOW: begin
								leg_q <= (item.quality > FULL_SCALE) ? FULL_SCALE
								                                     : item.quality;
								st_q  <= ST_SUM;
							end
							OP_ATTACH: attached_q <= 1'b1;
							OP_DETACH: attached_q <= 1'b0;
							default:   st_q <= ST_IDLE;
						endcase
					end
				end
				ST_SEARCH: begin
					if (v_s1) begin
						if (valid_q[idx_s1] && ram_rdata.peer == item_q.peer_id
						    && !found_q) begin
							found_q <= 1'b1;
						end
						if (!valid_q[idx_s1] && !free_found_q) begin
							free_found_q <= 1'b1;
						end
					end
					if (!issue && !v_s1) begin
						st_q <= (found_q || free_found_q) ? ST_WRITE : ST_IDLE;
					end
				end
				ST_WRITE: begin
					valid_q[ram_waddr] <= 1'b1;
					cnt_q <= '0;
					st_q  <= ST_SUM;
				end
				ST_SUM: begin
					if (!issue && !v_s1 && !v_s2) begin
						st_q <= ST_MULT;
					end
				end
				ST_MULT: st_q <= ST_CMP;
				ST_CMP:  st_q <= (num_q >= capden_q) ? ST_EMIT : ST_DIV;
				ST_DIV: begin
					if (k_q == 3'd0) begin
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (report) begin
						last_q_q     <= LAST_Q_W'(lq_q);
						last_rtt_q   <= worst_q;
					end
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			item_q <= item;
		end
		if (st_q == ST_SEARCH && v_s1) begin
			if (valid_q[idx_s1] && ram_rdata.peer == item_q.peer_id && !found_q) begin
				match_q <= idx_s1;
			end
			if (!valid_q[idx_s1] && !free_found_q) begin
				free_q <= idx_s1;
			end
		end
		// clear the sums as the sum sweep opens
		if ((st_q == ST_SUM && cnt_q == '0) || st_q == ST_WRITE) begin
			n_q     <= '0;
			wsum_q  <= '0;
			qsum_q  <= '0;
			bwsum_q <= '0;
			worst_q <= '0;
		end else if (v_s2) begin
			n_q     <= n_q + 1'b1;
			wsum_q  <= wsum_q + NUM_W'(prod_s2);
			qsum_q  <= qsum_q + QS_W'(q_s2);
			bwsum_q <= bwsum_q + BS_W'(bw_s2);
			if (rtt_s2 > worst_q) begin
				worst_q <= rtt_s2;
			end
		end
		if (st_q == ST_MULT) begin
			num_q    <= num_sel;
			den_q    <= den_sel;
			capden_q <= NUM_W'(leg_q) * NUM_W'(den_sel);
			rem_q    <= REM_W'(num_sel) + (REM_W'(den_sel) << 7);
			k_q      <= 3'd6;
		end
		if (st_q == ST_CMP && num_q >= capden_q) begin
			lq_q <= LQ_W'((16'(leg_q) + 16'd128) >> 8);
		end
		if (st_q == ST_DIV) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				lq_q  <= {lq_q[LQ_W-2:0], 1'b1};
			end else begin
				lq_q  <= {lq_q[LQ_W-2:0], 1'b0};
			end
			k_q <= k_q - 3'd1;
		end
	end

	assign result.quality_pct  = lq_q;
	assign result.worst_rtt_ms = worst_q;

	// a report is in range and only goes out while a reporter listens
	a_lq_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.quality_pct <= LQ_W'(100)))
		else $error("link quality out of range");

	a_attached: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> attached_q)
		else $error("report while detached");

	a_write_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_WRITE) |-> (found_q || free_found_q))
		else $error("table write without a slot");

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (st_q == ST_IDLE))
		else $error("report without returning to idle");

endmodule

// ===== dv/lqta_checker.sv =====
// Checker for the link quality telemetry aggregator: predicts reports and compares them.
module lqta_checker
	import lqta_pkg::*;
#(
	parameter int PEER_SLOTS = DEF_PEER_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  item_t             item,
	input  logic              result_valid,
	input  result_t           result,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [HYST_W-1:0] cfg_data,
	output int                fail_count,
	output int                pending
);

	logic              tbl_valid [PEER_SLOTS];
	entry_t            tbl       [PEER_SLOTS];
	logic [QUAL_W-1:0] leg_q;
	logic              attached;
	logic [7:0]        prev_q;
	logic [RTT_W-1:0]  prev_rtt;
	logic [HYST_W-1:0] hyst;
	result_t           reports [$];

	assign pending = reports.size();

	task automatic aggregate();
		logic [63:0] wsum, qsum, bwsum, num, den, cap, lq;
		logic [31:0] n, worst, diff;
		result_t r;
		wsum = 0; qsum = 0; bwsum = 0; n = 0; worst = 0;
		for (int i = 0; i < PEER_SLOTS; i++) begin
			if (tbl_valid[i]) begin
				n++;
				wsum += 64'(tbl[i].quality) * 64'(tbl[i].bandwidth);
				qsum += 64'(tbl[i].quality);
				bwsum += 64'(tbl[i].bandwidth);
				if (32'(tbl[i].rtt) > worst) worst = 32'(tbl[i].rtt);
			end
		end
		if (n == 0) begin
			num = 64'(FULL_SCALE); den = 1;
		end else if (bwsum == 0) begin
			num = qsum; den = 64'(n);
		end else begin
			num = wsum; den = bwsum;
		end
		cap = 64'(leg_q);
		if (num >= cap * den) lq = (cap + 128) >> 8;
		else lq = (num + 128 * den) / (256 * den);
		if (!attached) return;
		diff = (worst > 32'(prev_rtt)) ? worst - 32'(prev_rtt) : 32'(prev_rtt) - worst;
		if (lq[7:0] == prev_q && diff <= 32'(hyst)) return;
		prev_q = lq[7:0];
		prev_rtt = worst[RTT_W-1:0];
		r.quality_pct = lq[LQ_W-1:0];
		r.worst_rtt_ms = worst[RTT_W-1:0];
		reports.push_back(r);
	endtask

	task automatic apply_word(input item_t w);
		int hit, free_slot;
		hit = -1; free_slot = -1;
		case (w.op)
			OP_STATS: begin
				for (int i = 0; i < PEER_SLOTS; i++) begin
					if (tbl_valid[i] && tbl[i].peer == w.peer_id) begin
						hit = i;
						break;
					end
					if (!tbl_valid[i] && free_slot < 0) free_slot = i;
				end
				if (hit < 0) begin
					if (free_slot < 0) return;
					hit = free_slot;
					tbl_valid[hit] = 1'b1;
					tbl[hit].peer = w.peer_id;
				end
				tbl[hit].quality = w.quality;
				tbl[hit].rtt = w.rtt_ms;
				tbl[hit].bandwidth = w.bandwidth;
				aggregate();
			end
			OP_FLOW: begin
				leg_q = (w.quality > FULL_SCALE) ? FULL_SCALE : w.quality;
				aggregate();
			end
			OP_ATTACH: attached = 1'b1;
			default: attached = 1'b0;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < PEER_SLOTS; i++) tbl_valid[i] = 1'b0;
			leg_q = FULL_SCALE;
			attached = 1'b0;
			prev_q = LAST_Q_INIT;
			prev_rtt = LAST_R_INIT;
			hyst = HYST_RESET;
			reports.delete();
			fail_count = 0;
		end else begin
			// Compare a report before folding in this edge's word: it left earlier.
			if (result_valid) begin
				if (reports.size() == 0) begin
					$error("unexpected report: quality_pct %0d worst_rtt_ms %0d",
						result.quality_pct, result.worst_rtt_ms);
					fail_count++;
				end else begin
					exp_r = reports.pop_front();
					if (result.quality_pct !== exp_r.quality_pct) begin
						$error("quality_pct expected %0d actual %0d",
							exp_r.quality_pct, result.quality_pct);
						fail_count++;
					end
					if (result.worst_rtt_ms !== exp_r.worst_rtt_ms) begin
						$error("worst_rtt_ms expected %0d actual %0d",
							exp_r.worst_rtt_ms, result.worst_rtt_ms);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) hyst = cfg_data;
			if (start && !busy) apply_word(item);
		end
	end

endmodule

// ===== dv/link_quality_telemetry_aggregator_unit_tb.sv =====
// Testbench top for the link quality telemetry aggregator: stimulus and verdict.
module link_quality_telemetry_aggregator_unit_tb;
	import lqta_pkg::*;

	localparam int SLOTS = DEF_PEER_SLOTS;
	// Drain allowance: covers the longest stats word with margin.
	localparam int DRAIN = 4 * SLOTS + 40;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	item_t             item;
	logic              result_valid;
	result_t           result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [HYST_W-1:0] cfg_data;
	int                fail_count;
	int                pending;
	int                idle_pct;
	logic [31:0]       peer_pool [8];

	link_quality_telemetry_aggregator_unit #(.PEER_SLOTS(SLOTS)) DUT (
		.clk, .arst_n, .start, .busy, .item, .result_valid, .result,
		.cfg_valid, .cfg_ready, .cfg_data
	);

	lqta_checker #(.PEER_SLOTS(SLOTS)) checker_i (
		.clk, .arst_n, .start, .busy, .item, .result_valid, .result,
		.cfg_valid, .cfg_ready, .cfg_data, .fail_count, .pending
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// Hold one word on the item port until the block takes it, with random gaps before.
	// Start stays high after the take; the next call or a pause replaces or drops it.
	task automatic send_word(input item_t w);
		while (($urandom % 100) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic item_t make_word(input logic [1:0] op, input logic [31:0] id,
			input logic [14:0] q, input logic [23:0] rtt, input logic [31:0] bw);
		item_t w;
		w.op = op; w.peer_id = id; w.quality = q; w.rtt_ms = rtt; w.bandwidth = bw;
		return w;
	endfunction

	// Drain every expected report, let the block settle, then write the register.
	task automatic write_hyst(input logic [HYST_W-1:0] v);
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random quality: mostly legal, sometimes above full scale or at the extremes.
	function automatic logic [14:0] rand_q();
		case ($urandom_range(0, 9))
			0: return 15'h7FFF;
			1: return 15'($urandom_range(25601, 32767));
			2: return 15'd0;
			default: return 15'($urandom_range(0, 25600));
		endcase
	endfunction

	function automatic logic [31:0] rand_bw();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return 32'($urandom_range(0, 5000));
		endcase
	endfunction

	function automatic logic [23:0] rand_rtt();
		case ($urandom_range(0, 4))
			0: return 24'hFFFFFF;
			1: return 24'($urandom);
			default: return 24'($urandom_range(0, 400));
		endcase
	endfunction

	task automatic random_phase(input int count);
		item_t w;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 19))
				0: w = make_word(OP_ATTACH, $urandom, 15'($urandom), 24'($urandom), $urandom);
				1: w = make_word(OP_DETACH, $urandom, 15'($urandom), 24'($urandom), $urandom);
				2, 3: w = make_word(OP_FLOW, $urandom, rand_q(), 24'($urandom), $urandom);
				// New ids now and then fill the table and exercise the drop path.
				4: w = make_word(OP_STATS, $urandom, rand_q(), rand_rtt(), rand_bw());
				default: w = make_word(OP_STATS, peer_pool[$urandom_range(0, 7)],
					rand_q(), rand_rtt(), rand_bw());
			endcase
			send_word(w);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_pct = 0;
		foreach (peer_pool[i]) peer_pool[i] = $urandom;
		peer_pool[0] = 32'd0;
		peer_pool[1] = 32'hFFFF_FFFF;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: detached stats, attach, extremes, zero bandwidth, flow saturation.
		send_word(make_word(OP_STATS, 32'd0, 15'd25600, 24'd10, 32'd0));
		send_word(make_word(OP_ATTACH, '0, '0, '0, '0));
		send_word(make_word(OP_FLOW, '0, 15'h7FFF, '0, '0));
		send_word(make_word(OP_STATS, 32'd0, 15'd12800, 24'd10, 32'd0));
		send_word(make_word(OP_STATS, 32'hFFFF_FFFF, 15'h7FFF, 24'hFFFFFF, 32'hFFFF_FFFF));
		send_word(make_word(OP_STATS, 32'hFFFF_FFFF, 15'h7FFF, 24'hFFFFF0, 32'hFFFF_FFFF));
		send_word(make_word(OP_FLOW, '0, 15'd128, '0, '0));
		send_word(make_word(OP_FLOW, '0, 15'd127, '0, '0));
		send_word(make_word(OP_FLOW, '0, 15'd0, '0, '0));
		send_word(make_word(OP_FLOW, '0, 15'd25600, '0, '0));
		// Fill the table; the last new ids find no free slot and are dropped.
		for (int i = 2; i < 10; i++)
			send_word(make_word(OP_STATS, 32'(i * 77), 15'(i * 2000), 24'(i * 30), 32'(i)));
		send_word(make_word(OP_DETACH, '0, '0, '0, '0));
		send_word(make_word(OP_STATS, 32'h1234, 15'd0, 24'd5, 32'd0));
		send_word(make_word(OP_ATTACH, '0, '0, '0, '0));
		send_word(make_word(OP_STATS, 32'(2 * 77), 15'd0, 24'd0, 32'd100));

		// Reset clears the table; only reset can, so start random phases from a full table
		// whose entries are refreshed by id.
		peer_pool[2] = 32'(2 * 77);
		peer_pool[3] = 32'(3 * 77);
		write_hyst(16'd0);
		idle_pct = 19;
		random_phase(170);
		// Pause until every expected report has come out.
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		write_hyst(16'hFFFF);
		idle_pct = 45;
		random_phase(170);
		write_hyst(16'($urandom));
		idle_pct = 0;
		random_phase(160);

		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("FAILURE");
		$finish;
	end

endmodule
